// File: rtl/texel_format_to_rgba8_converter_unit_defines.svh
// Assertion macros for the texel converter.
// Included by modules that check their own pipeline control.
`ifndef TEXEL_FORMAT_TO_RGBA8_CONVERTER_UNIT_DEFINES_SVH
`define TEXEL_FORMAT_TO_RGBA8_CONVERTER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// checked outside reset
`define TFRC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("tfrc check failed");
// checked during reset as well
`define TFRC_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("tfrc reset check failed");
`else
`define TFRC_ASSERT(lbl, prop)
`define TFRC_ASSERT_RST(lbl, prop)
`endif
`endif

// File: rtl/tfrc_pkg.sv
// Shared types, format codes and channel widening helpers for the texel converter.
// No dependencies.
`timescale 1ns / 1ps
package tfrc_pkg;

  localparam logic [4:0] FMT_ARGB1555 = 5'd0;
  localparam logic [4:0] FMT_XRGB1555 = 5'd1;
  localparam logic [4:0] FMT_ARGB4444 = 5'd2;
  localparam logic [4:0] FMT_RGB565   = 5'd3;
  localparam logic [4:0] FMT_RGB655   = 5'd4;
  localparam logic [4:0] FMT_Y8       = 5'd5;
  localparam logic [4:0] FMT_AY8      = 5'd6;
  localparam logic [4:0] FMT_A8       = 5'd7;
  localparam logic [4:0] FMT_AY88     = 5'd8;
  localparam logic [4:0] FMT_RB88     = 5'd9;
  localparam logic [4:0] FMT_GB88     = 5'd10;
  localparam logic [4:0] FMT_ARGB8888 = 5'd11;
  localparam logic [4:0] FMT_XRGB8888 = 5'd12;
  localparam logic [4:0] FMT_ABGR8888 = 5'd13;
  localparam logic [4:0] FMT_BGRA8888 = 5'd14;
  localparam logic [4:0] FMT_RGBA8888 = 5'd15;
  localparam logic [4:0] FMT_PALETTE  = 5'd16;

  localparam logic FUNC_CONVERT   = 1'b0;
  localparam logic FUNC_PAL_WRITE = 1'b1;

  localparam logic REG_PIXEL_FORMAT = 1'b0;
  localparam logic REG_SIGN_FLAGS   = 1'b1;

  localparam int PAL_AW = 8;

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgba_t;

  function automatic logic [7:0] widen5(input logic [4:0] v);
    return {v, v[4:2]};
  endfunction

  function automatic logic [7:0] widen6(input logic [5:0] v);
    return {v, v[5:4]};
  endfunction

  function automatic logic [7:0] widen4(input logic [3:0] v);
    return {v, v};
  endfunction

endpackage

// File: rtl/tfrc_palette.sv
// 256 x 32 palette memory, one write port and one registered read port.
// Uses tfrc_pkg for the address width.
`timescale 1ns / 1ps
module tfrc_palette
  import tfrc_pkg::*;
(
  input  logic              clk,
  input  logic              wr_en,
  input  logic [PAL_AW-1:0] wr_addr,
  input  logic [31:0]       wr_data,
  input  logic              rd_en,
  input  logic [PAL_AW-1:0] rd_addr,
  output logic [31:0]       rd_data
);

  logic [31:0] mem [2**PAL_AW];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds until the next read so a stalled stage keeps its word
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/tfrc_unpack.sv
// Format decode: splits a raw texel or palette word into RGBA8 and applies sign flips.
// Uses tfrc_pkg for format codes, rgba_t and the widen helpers.
`timescale 1ns / 1ps
module tfrc_unpack
  import tfrc_pkg::*;
(
  input  logic [4:0]  pixel_format,
  input  logic [3:0]  sign_flags,
  input  logic [31:0] pixel_bits,
  input  logic [31:0] pal_word,
  output rgba_t       rgba
);

  logic [7:0] b0, b1, b2, b3;
  logic [7:0] r, g, b, a;

  assign b0 = pixel_bits[7:0];
  assign b1 = pixel_bits[15:8];
  assign b2 = pixel_bits[23:16];
  assign b3 = pixel_bits[31:24];

  always_comb begin
    r = 8'd0;
    g = 8'd0;
    b = 8'd0;
    a = 8'd0;
    case (pixel_format)
      FMT_ARGB1555: begin
        r = widen5(pixel_bits[14:10]);
        g = widen5(pixel_bits[9:5]);
        b = widen5(pixel_bits[4:0]);
        a = {8{pixel_bits[15]}};
      end
      FMT_XRGB1555: begin
        r = widen5(pixel_bits[14:10]);
        g = widen5(pixel_bits[9:5]);
        b = widen5(pixel_bits[4:0]);
        a = 8'hFF;
      end
      FMT_ARGB4444: begin
        r = widen4(b1[3:0]);
        g = widen4(b0[7:4]);
        b = widen4(b0[3:0]);
        a = widen4(b1[7:4]);
      end
      FMT_RGB565: begin
        r = widen5(pixel_bits[15:11]);
        g = widen6(pixel_bits[10:5]);
        b = widen5(pixel_bits[4:0]);
        a = 8'hFF;
      end
      FMT_RGB655: begin
        r = widen6(pixel_bits[15:10]);
        g = widen5(pixel_bits[9:5]);
        b = widen5(pixel_bits[4:0]);
        a = 8'hFF;
      end
      FMT_Y8: begin
        r = b0; g = b0; b = b0; a = 8'hFF;
      end
      FMT_AY8: begin
        r = b0; g = b0; b = b0; a = b0;
      end
      FMT_A8: begin
        r = 8'hFF; g = 8'hFF; b = 8'hFF; a = b0;
      end
      FMT_AY88: begin
        r = b0; g = b0; b = b0; a = b1;
      end
      FMT_RB88: begin
        r = b1; g = b0; b = b0; a = b1;
      end
      FMT_GB88: begin
        r = b0; g = b1; b = b0; a = b1;
      end
      FMT_ARGB8888: begin
        r = b2; g = b1; b = b0; a = b3;
      end
      FMT_XRGB8888: begin
        r = b2; g = b1; b = b0; a = 8'hFF;
      end
      FMT_ABGR8888: begin
        r = b0; g = b1; b = b2; a = b3;
      end
      FMT_BGRA8888: begin
        r = b1; g = b2; b = b3; a = b0;
      end
      FMT_RGBA8888: begin
        r = b3; g = b2; b = b1; a = b0;
      end
      FMT_PALETTE: begin
        r = pal_word[23:16];
        g = pal_word[15:8];
        b = pal_word[7:0];
        a = pal_word[31:24];
      end
      default: begin
        r = 8'd0; g = 8'd0; b = 8'd0; a = 8'd0;
      end
    endcase
  end

  // sign flag flips the channel MSB
  assign rgba.red   = r ^ {sign_flags[0], 7'd0};
  assign rgba.green = g ^ {sign_flags[1], 7'd0};
  assign rgba.blue  = b ^ {sign_flags[2], 7'd0};
  assign rgba.alpha = a ^ {sign_flags[3], 7'd0};

endmodule

// File: rtl/texel_format_to_rgba8_converter_unit.sv
// Texel converter top: palette read stage, decode stage and output register.
// A convert item passes the palette read stage and then the output register before it shows on m_tvalid.
// Throughput: one item per cycle unless m_tready stalls the output; the palette has one write
// and one read port and an item uses only one of them, so writes and reads never collide.
// Reset clears the configuration registers and the pipeline valids; palette contents are
// undefined until written, with no clearing pass.
`timescale 1ns / 1ps
`include "texel_format_to_rgba8_converter_unit_defines.svh"
module texel_format_to_rgba8_converter_unit
  import tfrc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,  // pixel_bits[31:0], palette_index[39:32], palette_word[71:40]
  input  logic        s_tuser,  // func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,  // red[7:0], green[15:8], blue[23:16], alpha[31:24]
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [4:0]  cfg_data
);

  logic [4:0]  pixel_format;
  logic [3:0]  sign_flags;

  logic        in_acc;
  logic        cvt_acc;
  logic        wr_acc;

  logic        s1_valid;
  logic        s1_move;
  logic [31:0] s1_pixel;
  logic [31:0] pal_rd_data;
  rgba_t       s1_rgba;

  logic        o_valid;
  rgba_t       o_rgba;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_format <= FMT_ARGB1555;
      sign_flags   <= 4'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PIXEL_FORMAT: pixel_format <= cfg_data;
        REG_SIGN_FLAGS:   sign_flags   <= cfg_data[3:0];
        default:          ;
      endcase
    end
  end

  assign s1_move  = s1_valid && (!o_valid || m_tready);
  assign s_tready = !s1_valid || s1_move;
  assign in_acc   = s_tvalid && s_tready;
  assign cvt_acc  = in_acc && (s_tuser == FUNC_CONVERT);
  assign wr_acc   = in_acc && (s_tuser == FUNC_PAL_WRITE);

  tfrc_palette u_palette (
    .clk     (clk),
    .wr_en   (wr_acc),
    .wr_addr (s_tdata[39:32]),
    .wr_data (s_tdata[71:40]),
    .rd_en   (cvt_acc),
    .rd_addr (s_tdata[7:0]),
    .rd_data (pal_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= cvt_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (cvt_acc) begin
      s1_pixel <= s_tdata[31:0];
    end
  end

  tfrc_unpack u_unpack (
    .pixel_format (pixel_format),
    .sign_flags   (sign_flags),
    .pixel_bits   (s1_pixel),
    .pal_word     (pal_rd_data),
    .rgba         (s1_rgba)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (!o_valid || m_tready) begin
      o_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      o_rgba <= s1_rgba;
    end
  end

  assign m_tvalid = o_valid;
  assign m_tdata  = o_rgba;

  `TFRC_ASSERT(a_s1_hold, s1_valid && !s1_move |=> s1_valid)
  `TFRC_ASSERT(a_pal_stable, s1_valid && !s1_move |=> $stable(pal_rd_data))
  `TFRC_ASSERT(a_cvt_enters, cvt_acc |=> s1_valid)
  `TFRC_ASSERT(a_wr_no_result, wr_acc |=> !s1_valid)
  `TFRC_ASSERT_RST(a_reset_clear, rst |=> !s1_valid && !o_valid)

endmodule

// File: tb/texel_format_to_rgba8_converter_unit_tb.sv
`timescale 1ns / 1ps
// Testbench for texel_format_to_rgba8_converter_unit: a self-checking stream test that covers
// every source format, the palette loads and the sign flags. It depends on tfrc_pkg and the top.
module texel_format_to_rgba8_converter_unit_tb;
  import tfrc_pkg::*;

  localparam int DRAIN_CYCLES = 6;
  localparam int STALL_LIMIT  = 2000;
  localparam int RAND_PHASES  = 32;
  localparam int ITEMS_PER_PHASE = 18;
  localparam int SIGN_RED   = 0;
  localparam int SIGN_GREEN = 1;
  localparam int SIGN_BLUE  = 2;
  localparam int SIGN_ALPHA = 3;

  typedef struct {
    logic        func;
    logic [31:0] pixel_bits;
    logic [7:0]  pal_idx;
    logic [31:0] pal_word;
  } texel_req_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata = '0;  // pixel_bits[31:0], palette_index[39:32], palette_word[71:40]
  logic        s_tuser = FUNC_CONVERT;  // func
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;  // red[7:0], green[15:8], blue[23:16], alpha[31:24]
  logic        cfg_we = 1'b0;
  logic        cfg_index = REG_PIXEL_FORMAT;
  logic [4:0]  cfg_data = '0;

  texel_format_to_rgba8_converter_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // stimulus side
  texel_req_t  texel_reqs[$];
  texel_req_t  cur_req;
  bit          pal_filled[256];
  logic [7:0]  filled_idx[$];
  int          send_gap_pct = 0;
  int          sink_stall_pct = 0;

  // predictor state
  logic [4:0]  model_fmt = FMT_ARGB1555;
  logic [3:0]  model_signs = '0;
  logic [31:0] pal_model[256];
  rgba_t       expected_rgba[$];

  int fault_count = 0;
  int texels_checked = 0;
  int pal_loads = 0;
  int reg_settings = 0;
  int stall_cycles = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  // copies the low nbits of v down the byte, msb first, until all 8 bits are filled
  function automatic logic [7:0] expand_channel(input logic [7:0] v, input int nbits);
    logic [7:0] acc;
    acc = '0;
    for (int k = 0; k < 8; k++) begin
      acc[7 - k] = v[nbits - 1 - (k % nbits)];
    end
    return acc;
  endfunction

  function automatic rgba_t convert_texel(input logic [4:0] fmt, input logic [3:0] signs,
                                          input logic [31:0] px);
    logic [7:0]  b0, b1, b2, b3;
    logic [15:0] h;
    logic [31:0] w;
    rgba_t       c;
    b0 = px[7:0];
    b1 = px[15:8];
    b2 = px[23:16];
    b3 = px[31:24];
    h  = px[15:0];
    c  = '0;
    case (fmt)
      FMT_ARGB1555, FMT_XRGB1555: begin
        c.red   = expand_channel(h[14:10], 5);
        c.green = expand_channel(h[9:5], 5);
        c.blue  = expand_channel(h[4:0], 5);
        c.alpha = (fmt == FMT_XRGB1555) ? 8'hFF : {8{h[15]}};
      end
      FMT_ARGB4444: begin
        c.red   = expand_channel(b1[3:0], 4);
        c.green = expand_channel(b0[7:4], 4);
        c.blue  = expand_channel(b0[3:0], 4);
        c.alpha = expand_channel(b1[7:4], 4);
      end
      FMT_RGB565: begin
        c.red   = expand_channel(h[15:11], 5);
        c.green = expand_channel(h[10:5], 6);
        c.blue  = expand_channel(h[4:0], 5);
        c.alpha = 8'hFF;
      end
      FMT_RGB655: begin
        c.red   = expand_channel(h[15:10], 6);
        c.green = expand_channel(h[9:5], 5);
        c.blue  = expand_channel(h[4:0], 5);
        c.alpha = 8'hFF;
      end
      FMT_Y8:       c = '{alpha: 8'hFF, blue: b0, green: b0, red: b0};
      FMT_AY8:      c = '{alpha: b0, blue: b0, green: b0, red: b0};
      FMT_A8:       c = '{alpha: b0, blue: 8'hFF, green: 8'hFF, red: 8'hFF};
      FMT_AY88:     c = '{alpha: b1, blue: b0, green: b0, red: b0};
      FMT_RB88:     c = '{alpha: b1, blue: b0, green: b0, red: b1};
      FMT_GB88:     c = '{alpha: b1, blue: b0, green: b1, red: b0};
      FMT_ARGB8888: c = '{alpha: b3, blue: b0, green: b1, red: b2};
      FMT_XRGB8888: c = '{alpha: 8'hFF, blue: b0, green: b1, red: b2};
      FMT_ABGR8888: c = '{alpha: b3, blue: b2, green: b1, red: b0};
      FMT_BGRA8888: c = '{alpha: b0, blue: b3, green: b2, red: b1};
      FMT_RGBA8888: c = '{alpha: b0, blue: b1, green: b2, red: b3};
      FMT_PALETTE: begin
        w = pal_model[b0];
        c = '{alpha: w[31:24], blue: w[7:0], green: w[15:8], red: w[23:16]};
      end
      default: ;  // unknown formats give zeros before the sign flips
    endcase
    c.red[7]   = c.red[7] ^ signs[SIGN_RED];
    c.green[7] = c.green[7] ^ signs[SIGN_GREEN];
    c.blue[7]  = c.blue[7] ^ signs[SIGN_BLUE];
    c.alpha[7] = c.alpha[7] ^ signs[SIGN_ALPHA];
    return c;
  endfunction

  task automatic flag_mismatch(input string what, input logic [7:0] got, input logic [7:0] want);
    fault_count++;
    $display("%0t: %s mismatch: got %02h want %02h (result %0d)", $time, what, got, want,
             texels_checked);
  endtask

  task automatic queue_pal_write(input logic [7:0] idx, input logic [31:0] word);
    texel_req_t r;
    r = '{func: FUNC_PAL_WRITE, pixel_bits: $urandom, pal_idx: idx, pal_word: word};
    texel_reqs.push_back(r);
    if (!pal_filled[idx]) filled_idx.push_back(idx);
    pal_filled[idx] = 1'b1;
  endtask

  task automatic queue_convert(input logic [31:0] px);
    texel_req_t r;
    r = '{func: FUNC_CONVERT, pixel_bits: px, pal_idx: 8'($urandom), pal_word: $urandom};
    texel_reqs.push_back(r);
  endtask

  // random item mix for one register setting; palette reads only hit loaded entries
  task automatic queue_random_items(input logic [4:0] fmt, input int count);
    logic [31:0] px;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(4) == 0) begin
        queue_pal_write(8'($urandom), $urandom);
      end else begin
        case ($urandom_range(7))
          0:       px = '0;
          1:       px = '1;
          default: px = $urandom;
        endcase
        if (fmt == FMT_PALETTE) px[7:0] = filled_idx[$urandom_range(filled_idx.size() - 1)];
        queue_convert(px);
      end
    end
  endtask

  // wait until the block is empty, then write both registers and pick the idle mix
  task automatic program_regs(input logic [4:0] fmt, input logic [3:0] signs, input int tier);
    @(negedge clk);
    while (texel_reqs.size() != 0 || s_tvalid || expected_rgba.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_PIXEL_FORMAT;
    cfg_data  <= fmt;
    @(posedge clk);
    cfg_index <= REG_SIGN_FLAGS;
    cfg_data  <= {1'b0, signs};
    @(posedge clk);
    cfg_we <= 1'b0;
    model_fmt   = fmt;
    model_signs = signs;
    reg_settings++;
    case (tier)
      0:       begin send_gap_pct = 12; sink_stall_pct = 50; end
      1:       begin send_gap_pct = 50; sink_stall_pct = 12; end
      default: begin send_gap_pct = 0;  sink_stall_pct = 0;  end
    endcase
    @(negedge clk);
  endtask

  task automatic predict_item(input texel_req_t r);
    if (r.func == FUNC_PAL_WRITE) begin
      pal_model[r.pal_idx] = r.pal_word;
      pal_loads++;
    end else begin
      expected_rgba.push_back(convert_texel(model_fmt, model_signs, r.pixel_bits));
    end
  endtask

  // input driver: one item per handshake, random gaps
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) predict_item(cur_req);
      if (!s_tvalid || s_tready) begin
        if (texel_reqs.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          cur_req = texel_reqs.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {cur_req.pal_word, cur_req.pal_idx, cur_req.pixel_bits};
          s_tuser  <= cur_req.func;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // output monitor with random back-pressure
  always @(posedge clk) begin
    rgba_t got, want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = rgba_t'(m_tdata);
        if (expected_rgba.size() == 0) begin
          fault_count++;
          $display("%0t: result %08h arrived with nothing expected", $time, m_tdata);
        end else begin
          want = expected_rgba.pop_front();
          if (got.red !== want.red)     flag_mismatch("red", got.red, want.red);
          if (got.green !== want.green) flag_mismatch("green", got.green, want.green);
          if (got.blue !== want.blue)   flag_mismatch("blue", got.blue, want.blue);
          if (got.alpha !== want.alpha) flag_mismatch("alpha", got.alpha, want.alpha);
        end
        texels_checked++;
      end
      m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // watchdog: too long without any handshake on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles == STALL_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
      $display("texel_format_to_rgba8_converter_unit verification failed");
      $finish;
    end
  end

  initial begin
    logic [3:0] signs;
    int         tier;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: palette extremes, write then read back to back
    program_regs(FMT_PALETTE, 4'd0, 0);
    queue_pal_write(8'h00, 32'h0000_0000);
    queue_pal_write(8'hFF, 32'hFFFF_FFFF);
    queue_pal_write(8'hA5, 32'h80FF_0001);
    queue_pal_write(8'h5A, 32'h7F00_FE80);
    queue_convert(32'hFFFF_FF00);
    queue_convert(32'h0000_00FF);
    queue_convert(32'h5A5A_5AA5);
    queue_convert(32'hA5A5_A55A);
    queue_pal_write(8'h00, 32'h1234_5678);
    queue_convert(32'h0000_0000);

    // directed: 1-bit alpha both ways, all channels flipped, upper bytes ignored
    program_regs(FMT_ARGB1555, 4'hF, 0);
    queue_convert(32'h0000_0000);
    queue_convert(32'hFFFF_FFFF);
    queue_convert(32'h0000_8000);
    queue_convert(32'hFFFF_7FFF);
    queue_pal_write(8'h3C, 32'hC3C3_3C3C);
    queue_convert(32'h5555_AAAA);

    // directed: unknown format
    program_regs(5'd31, 4'd0, 0);
    queue_convert(32'h0000_0000);
    queue_convert(32'hFFFF_FFFF);

    // random: walk every register value, idle mix changes by thirds
    for (int p = 0; p < RAND_PHASES; p++) begin
      signs = 4'(p);
      tier  = (p < 11) ? 0 : (p < 22) ? 1 : 2;
      program_regs(5'(p), signs, tier);
      queue_random_items(5'(p), ITEMS_PER_PHASE);
    end

    @(negedge clk);
    while (texel_reqs.size() != 0 || s_tvalid || expected_rgba.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_rgba.size() != 0) begin
      fault_count++;
      $display("%0d expected results never arrived", expected_rgba.size());
    end

    $display("checked %0d converted texels and %0d palette loads over %0d register settings",
             texels_checked, pal_loads, reg_settings);
    $display("formats 0..31 and sign masks 0..15 exercised, %0d mismatches", fault_count);
    if (fault_count == 0) begin
      $display("texel_format_to_rgba8_converter_unit verification clean");
    end else begin
      $display("texel_format_to_rgba8_converter_unit verification failed");
    end
    $finish;
  end

endmodule
